FILE: sv/rar_pkg.sv
package rar_pkg;

   localparam int OPERAND_WIDTH = 16;
   localparam int PROD_WIDTH    = 2 * OPERAND_WIDTH;
   localparam int SUM_WIDTH     = PROD_WIDTH + 1;
   localparam int MAG_WIDTH     = PROD_WIDTH;
   localparam int RES_NUM_WIDTH = 33;
   localparam int RES_DEN_WIDTH = 32;
   localparam int STATUS_WIDTH  = 2;

   localparam logic [1:0] OP_ADD = 2'd0;
   localparam logic [1:0] OP_SUB = 2'd1;
   localparam logic [1:0] OP_MUL = 2'd2;
   localparam logic [1:0] OP_DIV = 2'd3;

   localparam logic [STATUS_WIDTH-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_ZERO_DEN = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_DIV_ZERO = 2'd2;

   typedef struct packed {
      logic [1:0]                      op;
      logic signed [OPERAND_WIDTH-1:0] a_num;
      logic signed [OPERAND_WIDTH-1:0] a_den;
      logic signed [OPERAND_WIDTH-1:0] b_num;
      logic signed [OPERAND_WIDTH-1:0] b_den;
   } rar_req_type;

   typedef struct packed {
      logic signed [RES_NUM_WIDTH-1:0] res_num;
      logic signed [RES_DEN_WIDTH-1:0] res_den;
      logic [STATUS_WIDTH-1:0]         status;
   } rar_rsp_type;

endpackage

FILE: sv/rational_arith_reduce_core.sv
// Reduced fraction arithmetic: one word on req_data carries two signed fractions and an op
// (add, subtract, multiply, divide); one word on rsp_data returns the cross-multiplied result
// divided by the gcd of its magnitudes, signs as computed (the denominator may be negative).
// A zero input denominator, or divide by a zero fraction, returns status and zero fields.
// One item at a time: req_stall is high from acceptance until the result is loaded into the
// output register. A good item passes through acceptance, three products on the shared
// multiplier, then sum, magnitude and start, a binary gcd on the shared subtractor, two
// restoring divides of 2*OPERAND_WIDTH steps each on that same subtractor, a state to pick up
// done and one to load the output. Error items go from acceptance straight to the output
// load. A stalled output register holds the item until the register is free again.
module rational_arith_reduce_core
   import rar_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  rar_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rar_rsp_type rsp_data
);

   localparam int W  = OPERAND_WIDTH;
   localparam int PW = PROD_WIDTH;
   localparam int SW = SUM_WIDTH;
   localparam int MW = MAG_WIDTH;
   localparam int XW = (MW + 1 > RES_NUM_WIDTH) ? MW + 1 : RES_NUM_WIDTH;

   localparam logic [3:0] T_IDLE = 4'd0;
   localparam logic [3:0] T_MUL0 = 4'd1;
   localparam logic [3:0] T_MUL1 = 4'd2;
   localparam logic [3:0] T_MUL2 = 4'd3;
   localparam logic [3:0] T_SUM  = 4'd4;
   localparam logic [3:0] T_ABS  = 4'd5;
   localparam logic [3:0] T_GO   = 4'd6;
   localparam logic [3:0] T_RED  = 4'd7;
   localparam logic [3:0] T_OUT  = 4'd8;

   logic [3:0]              state_ff;
   logic [3:0]              state_in;
   logic [1:0]              op_ff;
   logic signed [W-1:0]     an_ff;
   logic signed [W-1:0]     ad_ff;
   logic signed [W-1:0]     bn_ff;
   logic signed [W-1:0]     bd_ff;
   logic [PW-1:0]           t1_ff;
   logic [PW-1:0]           t2_ff;
   logic [PW-1:0]           den_ff;
   logic [SW-1:0]           num_ff;
   logic [MW-1:0]           nm_ff;
   logic [MW-1:0]           dm_ff;
   logic                    nneg_ff;
   logic                    dneg_ff;
   logic [STATUS_WIDTH-1:0] status_ff;
   logic                    rsp_valid_ff;
   rar_rsp_type             rsp_ff;

   logic signed [W-1:0]  mul_a;
   logic signed [W-1:0]  mul_b;
   logic signed [PW-1:0] mul_p;
   logic [SW-1:0]        t1x;
   logic [SW-1:0]        t2x;
   logic [SW-1:0]        sum;
   logic [SW-1:0]        num_neg;
   logic [MW-1:0]        den_neg;
   logic                 req_take;
   logic                 out_free;
   logic                 unit_done;
   logic [MW-1:0]        quo_num;
   logic [MW-1:0]        quo_den;
   logic [XW-1:0]        qnx;
   logic [XW-1:0]        qdx;
   logic [XW-1:0]        snum;
   logic [XW-1:0]        sden;
   rar_rsp_type          rsp_in;

   rar_reduce_unit u_reduce (
      .clock   (clock),
      .reset   (reset),
      .start   (state_ff == T_GO),
      .num_mag (nm_ff),
      .den_mag (dm_ff),
      .done    (unit_done),
      .quo_num (quo_num),
      .quo_den (quo_den)
   );

   assign req_stall = (state_ff != T_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // shared multiplier, operands picked by step
   always_comb begin
      mul_a = an_ff;
      mul_b = bd_ff;
      case (state_ff)
         T_MUL0: begin
            mul_a = an_ff;
            mul_b = (op_ff == OP_MUL) ? bn_ff : bd_ff;
         end
         T_MUL1: begin
            mul_a = bn_ff;
            mul_b = ad_ff;
         end
         T_MUL2: begin
            mul_a = ad_ff;
            mul_b = (op_ff == OP_DIV) ? bn_ff : bd_ff;
         end
         default: begin
            mul_a = an_ff;
            mul_b = bd_ff;
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   always_comb begin
      t1x = {t1_ff[PW-1], t1_ff};
      t2x = {t2_ff[PW-1], t2_ff};
      case (op_ff)
         OP_ADD:  sum = t1x + t2x;
         OP_SUB:  sum = t1x - t2x;
         default: sum = t1x;
      endcase
      num_neg = SW'(0) - num_ff;
      den_neg = MW'(0) - den_ff;
   end

   always_comb begin
      qnx  = {{(XW - MW){1'b0}}, quo_num};
      qdx  = {{(XW - MW){1'b0}}, quo_den};
      snum = nneg_ff ? XW'(0) - qnx : qnx;
      sden = dneg_ff ? XW'(0) - qdx : qdx;
      if (status_ff == ST_OK) begin
         rsp_in.res_num = snum[RES_NUM_WIDTH-1:0];
         rsp_in.res_den = sden[RES_DEN_WIDTH-1:0];
      end else begin
         rsp_in.res_num = '0;
         rsp_in.res_den = '0;
      end
      rsp_in.status = status_ff;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         T_IDLE: begin
            if (req_take) begin
               if (req_data.a_den == '0 || req_data.b_den == '0 ||
                   (req_data.op == OP_DIV && req_data.b_num == '0)) begin
                  state_in = T_OUT;
               end else begin
                  state_in = T_MUL0;
               end
            end
         end
         T_MUL0: state_in = T_MUL1;
         T_MUL1: state_in = T_MUL2;
         T_MUL2: state_in = T_SUM;
         T_SUM:  state_in = T_ABS;
         T_ABS:  state_in = T_GO;
         T_GO:   state_in = T_RED;
         T_RED: begin
            if (unit_done) begin
               state_in = T_OUT;
            end
         end
         T_OUT: begin
            if (out_free) begin
               state_in = T_IDLE;
            end
         end
         default: state_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == T_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff <= req_data.op;
         an_ff <= req_data.a_num;
         ad_ff <= req_data.a_den;
         bn_ff <= req_data.b_num;
         bd_ff <= req_data.b_den;
         if (req_data.a_den == '0 || req_data.b_den == '0) begin
            status_ff <= ST_ZERO_DEN;
         end else if (req_data.op == OP_DIV && req_data.b_num == '0) begin
            status_ff <= ST_DIV_ZERO;
         end else begin
            status_ff <= ST_OK;
         end
      end
      if (state_ff == T_MUL0) begin
         t1_ff <= mul_p;
      end
      if (state_ff == T_MUL1) begin
         t2_ff <= mul_p;
      end
      if (state_ff == T_MUL2) begin
         den_ff <= mul_p;
      end
      if (state_ff == T_SUM) begin
         num_ff <= sum;
      end
      if (state_ff == T_ABS) begin
         nneg_ff <= num_ff[SW-1];
         dneg_ff <= den_ff[PW-1];
         nm_ff   <= num_ff[SW-1] ? num_neg[MW-1:0] : num_ff[MW-1:0];
         dm_ff   <= den_ff[PW-1] ? den_neg : den_ff;
      end
      if (state_ff == T_OUT && out_free) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: sv/rar_reduce_unit.sv
module rar_reduce_unit
   import rar_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [MAG_WIDTH-1:0] num_mag,
   input  logic [MAG_WIDTH-1:0] den_mag,
   output logic                 done,
   output logic [MAG_WIDTH-1:0] quo_num,
   output logic [MAG_WIDTH-1:0] quo_den
);

   localparam int MW = MAG_WIDTH;
   localparam int CW = $clog2(MW);

   localparam logic [1:0] U_IDLE = 2'd0;
   localparam logic [1:0] U_GCD  = 2'd1;
   localparam logic [1:0] U_DIVN = 2'd2;
   localparam logic [1:0] U_DIVD = 2'd3;

   logic [1:0]    state_ff;
   logic          done_ff;
   logic [MW-1:0] p_ff;
   logic [MW-1:0] q_ff;
   logic [MW-1:0] nsv_ff;
   logic [MW-1:0] dsv_ff;
   logic [MW-1:0] rem_ff;
   logic [MW-1:0] dvd_ff;
   logic [MW-1:0] qn_ff;
   logic [CW-1:0] cnt_ff;

   logic [MW:0]   sub_a;
   logic [MW:0]   sub_b;
   logic [MW+1:0] diff;
   logic          borrow;
   logic [MW-1:0] rem_next;
   logic [MW-1:0] quo_next;
   logic          last;

   // one subtractor serves the gcd compare and every divide step
   always_comb begin
      if (state_ff == U_GCD) begin
         sub_a = {1'b0, p_ff};
      end else begin
         sub_a = {rem_ff, dvd_ff[MW-1]};
      end
      sub_b    = {1'b0, q_ff};
      diff     = {1'b0, sub_a} - {1'b0, sub_b};
      borrow   = diff[MW+1];
      rem_next = borrow ? sub_a[MW-1:0] : diff[MW-1:0];
      quo_next = {dvd_ff[MW-2:0], ~borrow};
      last     = (cnt_ff == CW'(MW - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= (state_ff == U_DIVD) && last;
         unique case (state_ff)
            U_IDLE: begin
               if (start) begin
                  p_ff     <= num_mag;
                  q_ff     <= den_mag;
                  nsv_ff   <= num_mag;
                  dsv_ff   <= den_mag;
                  state_ff <= U_GCD;
               end
            end
            U_GCD: begin
               // binary gcd; common factors of two are stripped from the
               // saved operands as well, so q ends as the divisor
               if (p_ff == '0) begin
                  dvd_ff   <= nsv_ff;
                  rem_ff   <= '0;
                  cnt_ff   <= '0;
                  state_ff <= U_DIVN;
               end else if (!p_ff[0] && !q_ff[0]) begin
                  p_ff   <= p_ff >> 1;
                  q_ff   <= q_ff >> 1;
                  nsv_ff <= nsv_ff >> 1;
                  dsv_ff <= dsv_ff >> 1;
               end else if (!p_ff[0]) begin
                  p_ff <= p_ff >> 1;
               end else if (!q_ff[0]) begin
                  q_ff <= q_ff >> 1;
               end else if (borrow) begin
                  p_ff <= q_ff;
                  q_ff <= p_ff;
               end else begin
                  p_ff <= diff[MW:1];
               end
            end
            U_DIVN: begin
               if (last) begin
                  qn_ff    <= quo_next;
                  dvd_ff   <= dsv_ff;
                  rem_ff   <= '0;
                  cnt_ff   <= '0;
                  state_ff <= U_DIVD;
               end else begin
                  rem_ff <= rem_next;
                  dvd_ff <= quo_next;
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            U_DIVD: begin
               rem_ff <= rem_next;
               dvd_ff <= quo_next;
               cnt_ff <= cnt_ff + 1'b1;
               if (last) begin
                  state_ff <= U_IDLE;
               end
            end
            default: begin
               state_ff <= U_IDLE;
            end
         endcase
      end
   end

   assign done    = done_ff;
   assign quo_num = qn_ff;
   assign quo_den = dvd_ff;

endmodule
